@@ hw/rtl/fpalu_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, status codes and pipeline control types shared by the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpalu_pkg;

  localparam int VAL_BITS = 64;

  typedef enum logic [3:0] {
    OP_INT2FIX  = 4'd0,
    OP_FIX2INT  = 4'd1,
    OP_FIX2INTR = 4'd2,
    OP_ADD      = 4'd3,
    OP_ADDINT   = 4'd4,
    OP_SUB      = 4'd5,
    OP_SUBINT   = 4'd6,
    OP_MULINT   = 4'd7,
    OP_MUL      = 4'd8,
    OP_DIVINT   = 4'd9,
    OP_DIV      = 4'd10
  } req_op_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg;
    logic dz;
  } ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/fixed_point_17_14_alu.sv @@
// Signed fixed-point ALU (Q17.14 at the default parameters). One transaction
// is accepted per cycle while the input is not stalled, and every transaction,
// whatever its opcode, passes through the whole pipeline and leaves in order.
// The pipeline depth is set by the divider: a restoring divider with one
// quotient bit per pipeline stage. A stall on the output freezes the whole
// pipeline, so the input is stalled exactly when a finished result waits and is not taken.
// ----------------------------------------------------------------------------
// Fixed-point ALU top level
// Conversions, add, subtract, multiply and divide with overflow and divide-by-zero status.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_17_14_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_o,
  output logic [1:0]       status_o
);
  import fpalu_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int Q = WORD_BITS + FRAC_BITS;
  localparam logic signed [VAL_BITS-1:0] HALF  = VAL_BITS'(64'sd1 <<< (F - 1));
  localparam logic signed [VAL_BITS-1:0] FMASK = VAL_BITS'((64'sd1 <<< F) - 64'sd1);

  logic adv;
  logic out_valid_q;
  logic [31:0] result_q;
  logic [1:0]  status_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- Stage 1: decode, multiply, simple arithmetic
  req_op_e op_in;
  logic signed [W-1:0] a_w, b_w;
  logic signed [VAL_BITS-1:0] a64, b64;
  logic signed [2*W-1:0] prod_full;
  logic signed [VAL_BITS-1:0] val1_d;
  logic [W-1:0] amag, bmag;
  logic [Q-1:0] dvd1_d;
  ctrl_t ctl1_d;

  req_op_e op1_q;
  logic signed [VAL_BITS-1:0] val1_q, prod1_q;
  logic [Q-1:0] dvd1_q;
  logic [W-1:0] dvs1_q;
  ctrl_t ctl1_q;

  always_comb begin
    op_in     = req_op_e'(req_type_i);
    a_w       = operand_a_i[W-1:0];
    b_w       = operand_b_i[W-1:0];
    a64       = VAL_BITS'(a_w);
    b64       = VAL_BITS'(b_w);
    prod_full = a_w * b_w;
    amag      = a_w[W-1] ? W'(-a_w) : W'(a_w);
    bmag      = b_w[W-1] ? W'(-b_w) : W'(b_w);
    dvd1_d    = (op_in == OP_DIV) ? (Q'(amag) << F) : Q'(amag);
    unique case (op_in)
      OP_INT2FIX:  val1_d = a64 <<< F;
      OP_FIX2INT:  val1_d = a64;
      OP_FIX2INTR: val1_d = a_w[W-1] ? (a64 - HALF) : (a64 + HALF);
      OP_ADD:      val1_d = a64 + b64;
      OP_ADDINT:   val1_d = a64 + (b64 <<< F);
      OP_SUB:      val1_d = a64 - b64;
      OP_SUBINT:   val1_d = a64 - (b64 <<< F);
      default:     val1_d = '0;
    endcase
    ctl1_d.valid  = in_valid_i;
    ctl1_d.is_div = (op_in == OP_DIVINT) || (op_in == OP_DIV);
    ctl1_d.neg    = a_w[W-1] ^ b_w[W-1];
    ctl1_d.dz     = ctl1_d.is_div && (b_w == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= op_in;
      val1_q  <= val1_d;
      prod1_q <= VAL_BITS'(prod_full);
      dvd1_q  <= dvd1_d;
      dvs1_q  <= bmag;
    end
  end

  // ---------------- Stage 2: truncating shift toward zero, product select
  logic signed [VAL_BITS-1:0] tval, val2_d;

  logic [W-1:0]               rem_q [0:Q];
  logic [Q-1:0]               dvd_q [0:Q];
  logic [W-1:0]               dvs_q [0:Q];
  logic signed [VAL_BITS-1:0] dv_q  [0:Q];
  ctrl_t                      dctl_q[0:Q];

  always_comb begin
    tval = (op1_q == OP_MUL) ? prod1_q : val1_q;
    if (op1_q == OP_FIX2INT || op1_q == OP_FIX2INTR || op1_q == OP_MUL) begin
      // A negative value is biased so the arithmetic shift rounds toward zero.
      val2_d = (tval + (tval[VAL_BITS-1] ? FMASK : VAL_BITS'(0))) >>> F;
    end else if (op1_q == OP_MULINT) begin
      val2_d = prod1_q;
    end else begin
      val2_d = val1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dctl_q[0] <= '0;
    end else if (adv) begin
      dctl_q[0] <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= '0;
      dvd_q[0] <= dvd1_q;
      dvs_q[0] <= dvs1_q;
      dv_q[0]  <= val2_d;
    end
  end

  // ---------------- Divider: one restoring step per stage
  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [W:0] trial, diff;
    logic       take;

    always_comb begin
      trial = {rem_q[k], dvd_q[k][Q-1]};
      diff  = trial - {1'b0, dvs_q[k]};
      take  = (trial >= {1'b0, dvs_q[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dctl_q[k+1] <= '0;
      end else if (adv) begin
        dctl_q[k+1] <= dctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1] <= take ? diff[W-1:0] : trial[W-1:0];
        dvd_q[k+1] <= {dvd_q[k][Q-2:0], take};
        dvs_q[k+1] <= dvs_q[k];
        dv_q[k+1]  <= dv_q[k];
      end
    end
  end

  // ---------------- Final stage: sign, wrap and status
  logic signed [VAL_BITS-1:0] qv, fval;
  logic [VAL_BITS-W:0]        hi_bits;
  logic signed [W-1:0]        wrapped;
  logic [31:0]                result_d;
  logic [1:0]                 status_d;

  always_comb begin
    qv      = VAL_BITS'(dvd_q[Q]);
    fval    = dctl_q[Q].is_div ? (dctl_q[Q].neg ? -qv : qv) : dv_q[Q];
    hi_bits = fval[VAL_BITS-1:W-1];
    wrapped = fval[W-1:0];
    if (dctl_q[Q].dz) begin
      result_d = '0;
      status_d = ST_DZ;
    end else begin
      result_d = 32'(wrapped);
      status_d = ((&hi_bits) || !(|hi_bits)) ? ST_OK : ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dctl_q[Q].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DZ) |-> (result_o == '0))
    else $error("divide by zero result is not zero");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_OVF || status_o == ST_DZ))
    else $error("undefined status code");

  a_dz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dctl_q[Q].dz |-> dctl_q[Q].is_div)
    else $error("divide by zero flagged on a non-divide transaction");
`endif

endmodule

`default_nettype wire
